>>> rtl/gsfc_pkg.sv
// Shared types and constants for the gas sensor frame checker.
// No dependencies; the modules and the bench refer to it by scoped names.
`timescale 1ns / 1ps

package gsfc_pkg;

  // Frame layout
  localparam int FRAME_LEN  = 9;
  localparam int IDX_W      = 4;
  localparam int CNT_W      = 3;
  localparam int SUM_FIRST  = 1;
  localparam int SUM_LAST   = 7;
  localparam int CSUM_IDX   = 8;
  localparam int PPM_HI_IDX = 2;
  localparam int PPM_LO_IDX = 3;

  // Input transaction kinds
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_GOOD      = 2'd0,
    STATUS_BAD_SUM   = 2'd1,
    STATUS_NOT_READY = 2'd2
  } status_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUM,
    ST_FINISH
  } state_t;

  // Controls from the sequencer to the frame store
  typedef struct packed {
    logic wr_en;
    logic clear;
  } store_ctrl_t;

  // Controls from the sequencer to the checksum accumulator
  typedef struct packed {
    logic clr;
    logic add;
  } sum_ctrl_t;

endpackage

>>> rtl/gsfc_in_if.sv
// Input channel: received bytes and read events with valid/ready.
// Depends on nothing.
`timescale 1ns / 1ps

interface gsfc_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] rx_byte;

  modport source (output valid, output opcode, output rx_byte, input ready);
  modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

>>> rtl/gsfc_out_if.sv
// Result channel: concentration and read status with valid/ready.
// Depends on nothing.
`timescale 1ns / 1ps

interface gsfc_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] gas_ppm;
  logic [1:0]  read_status;

  modport source (output valid, output gas_ppm, output read_status, input ready);
  modport sink   (input valid, input gas_ppm, input read_status, output ready);
endinterface

>>> rtl/gas_sensor_frame_checker_top.sv
// Channel  Dir  Payload                          Accepted when
// cmd      in   opcode(1), rx_byte(8)            cmd.valid && cmd.ready
// rsp      out  gas_ppm(16), read_status(2)      rsp.valid && rsp.ready
//
// A received byte is written while idle. A read event is accepted while
// idle, the shared accumulator then adds bytes 1..7, and the commit follows;
// the commit waits while an earlier result still sits in the output register.
// rst is synchronous and clears the frame store, flags, held value and state.
// Depends on gsfc_pkg, gsfc_in_if, gsfc_out_if, gsfc_frame_store,
// gsfc_sum_unit and gsfc_ctrl.
`timescale 1ns / 1ps

module gas_sensor_frame_checker_top (
  input  logic             clk,
  input  logic             rst,
  gsfc_in_if.sink          cmd,
  gsfc_out_if.source       rsp
);

  gsfc_pkg::store_ctrl_t       store_ctrl;
  gsfc_pkg::sum_ctrl_t         sum_ctrl;
  logic [gsfc_pkg::IDX_W-1:0]  rd_addr;
  logic [7:0]                  rd_byte;
  logic [7:0]                  hi_byte;
  logic [7:0]                  lo_byte;
  logic [7:0]                  csum_byte;
  logic                        frame_ready;
  logic                        match;
  logic                        commit;
  logic                        out_free;
  logic                        out_valid;
  logic [15:0]                 held_ppm;
  gsfc_pkg::status_t           status;

  assign out_free = !out_valid || rsp.ready;

  gsfc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (cmd.valid),
    .in_opcode  (cmd.opcode),
    .out_free   (out_free),
    .in_ready   (cmd.ready),
    .store_ctrl (store_ctrl),
    .sum_ctrl   (sum_ctrl),
    .rd_addr    (rd_addr),
    .commit     (commit)
  );

  gsfc_frame_store u_store (
    .clk         (clk),
    .rst         (rst),
    .ctrl        (store_ctrl),
    .wr_byte     (cmd.rx_byte),
    .rd_addr     (rd_addr),
    .rd_byte     (rd_byte),
    .hi_byte     (hi_byte),
    .lo_byte     (lo_byte),
    .csum_byte   (csum_byte),
    .frame_ready (frame_ready)
  );

  gsfc_sum_unit u_sum (
    .clk       (clk),
    .ctrl      (sum_ctrl),
    .add_byte  (rd_byte),
    .csum_byte (csum_byte),
    .match     (match)
  );

  // Latch the result; held value changes only on a commit
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      held_ppm  <= 16'd0;
      status    <= gsfc_pkg::STATUS_GOOD;
    end else if (commit) begin
      out_valid <= 1'b1;
      if (!frame_ready) begin
        held_ppm <= 16'd0;
        status   <= gsfc_pkg::STATUS_NOT_READY;
      end else if (match) begin
        held_ppm <= {hi_byte, lo_byte};
        status   <= gsfc_pkg::STATUS_GOOD;
      end else begin
        status <= gsfc_pkg::STATUS_BAD_SUM;
      end
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.gas_ppm     = held_ppm;
  assign rsp.read_status = status;

endmodule

>>> rtl/gsfc_frame_store.sv
// Nine-byte frame store with write index and frame-ready flag.
// Depends on gsfc_pkg.
`timescale 1ns / 1ps

module gsfc_frame_store (
  input  logic                        clk,
  input  logic                        rst,
  input  gsfc_pkg::store_ctrl_t       ctrl,
  input  logic [7:0]                  wr_byte,
  input  logic [gsfc_pkg::IDX_W-1:0]  rd_addr,
  output logic [7:0]                  rd_byte,
  output logic [7:0]                  hi_byte,
  output logic [7:0]                  lo_byte,
  output logic [7:0]                  csum_byte,
  output logic                        frame_ready
);

  logic [7:0]                 frame [gsfc_pkg::FRAME_LEN];
  logic [gsfc_pkg::IDX_W-1:0] windex;

  // Fill at the write index, wrap after the last byte, clear on a read
  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      for (int i = 0; i < gsfc_pkg::FRAME_LEN; i++) begin
        frame[i] <= 8'd0;
      end
      windex      <= '0;
      frame_ready <= 1'b0;
    end else if (ctrl.wr_en) begin
      frame[windex] <= wr_byte;
      if (windex == gsfc_pkg::IDX_W'(gsfc_pkg::FRAME_LEN - 1)) begin
        windex      <= '0;
        frame_ready <= 1'b1;
      end else begin
        windex <= windex + 1'b1;
      end
    end
  end

  // Sequenced read port plus fixed taps
  assign rd_byte   = frame[rd_addr];
  assign hi_byte   = frame[gsfc_pkg::PPM_HI_IDX];
  assign lo_byte   = frame[gsfc_pkg::PPM_LO_IDX];
  assign csum_byte = frame[gsfc_pkg::CSUM_IDX];

endmodule

>>> rtl/gsfc_sum_unit.sv
// Shared byte accumulator and negated-sum compare for the checksum.
// Depends on gsfc_pkg.
`timescale 1ns / 1ps

module gsfc_sum_unit (
  input  logic                  clk,
  input  gsfc_pkg::sum_ctrl_t   ctrl,
  input  logic [7:0]            add_byte,
  input  logic [7:0]            csum_byte,
  output logic                  match
);

  logic [7:0] acc;

  // Accumulate one byte per cycle, mod 256
  always_ff @(posedge clk) begin
    if (ctrl.clr) begin
      acc <= 8'd0;
    end else if (ctrl.add) begin
      acc <= acc + add_byte;
    end
  end

  // Checksum byte must equal the two's-complement of the sum
  assign match = ((8'd0 - acc) == csum_byte);

endmodule

>>> rtl/gsfc_ctrl.sv
// Sequencer: accepts transactions, steps the accumulator over bytes 1..7,
// then commits the result when the output register is free. Depends on gsfc_pkg.
`timescale 1ns / 1ps

module gsfc_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_opcode,
  input  logic                        out_free,
  output logic                        in_ready,
  output gsfc_pkg::store_ctrl_t       store_ctrl,
  output gsfc_pkg::sum_ctrl_t         sum_ctrl,
  output logic [gsfc_pkg::IDX_W-1:0]  rd_addr,
  output logic                        commit
);

  gsfc_pkg::state_t             state;
  gsfc_pkg::state_t             state_next;
  logic [gsfc_pkg::CNT_W-1:0]   cnt;
  logic                         accept_read;

  assign accept_read = in_valid && in_ready && (in_opcode == gsfc_pkg::OP_READ);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      gsfc_pkg::ST_IDLE: begin
        if (accept_read) state_next = gsfc_pkg::ST_SUM;
      end
      gsfc_pkg::ST_SUM: begin
        if (cnt == gsfc_pkg::CNT_W'(gsfc_pkg::SUM_LAST)) state_next = gsfc_pkg::ST_FINISH;
      end
      gsfc_pkg::ST_FINISH: begin
        if (out_free) state_next = gsfc_pkg::ST_IDLE;
      end
      default: state_next = gsfc_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready         = 1'b0;
    store_ctrl.wr_en = 1'b0;
    store_ctrl.clear = 1'b0;
    sum_ctrl.clr     = 1'b0;
    sum_ctrl.add     = 1'b0;
    commit           = 1'b0;
    case (state)
      gsfc_pkg::ST_IDLE: begin
        in_ready         = 1'b1;
        store_ctrl.wr_en = in_valid && (in_opcode == gsfc_pkg::OP_BYTE);
        sum_ctrl.clr     = in_valid && (in_opcode == gsfc_pkg::OP_READ);
      end
      gsfc_pkg::ST_SUM: begin
        sum_ctrl.add = 1'b1;
      end
      gsfc_pkg::ST_FINISH: begin
        commit           = out_free;
        store_ctrl.clear = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign rd_addr = gsfc_pkg::IDX_W'(cnt);

  // State and byte counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gsfc_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (accept_read) begin
        cnt <= gsfc_pkg::CNT_W'(gsfc_pkg::SUM_FIRST);
      end else if (state == gsfc_pkg::ST_SUM) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_read_starts_sum: assert property (@(posedge clk) disable iff (rst)
    accept_read |=> (state == gsfc_pkg::ST_SUM) &&
                    (cnt == gsfc_pkg::CNT_W'(gsfc_pkg::SUM_FIRST)))
    else $error("read transaction did not start the sum at byte 1");

  a_sum_ends: assert property (@(posedge clk) disable iff (rst)
    (state == gsfc_pkg::ST_SUM) && (cnt == gsfc_pkg::CNT_W'(gsfc_pkg::SUM_LAST))
    |=> (state == gsfc_pkg::ST_FINISH))
    else $error("sum did not stop after byte 7");

  a_clear_on_commit: assert property (@(posedge clk) disable iff (rst)
    store_ctrl.clear |-> commit && (state == gsfc_pkg::ST_FINISH))
    else $error("frame store cleared outside a commit");

  a_no_write_while_sum: assert property (@(posedge clk) disable iff (rst)
    sum_ctrl.add |-> !store_ctrl.wr_en && !store_ctrl.clear)
    else $error("frame store changed during summing");
`endif

endmodule

>>> bench/tb_gas_sensor_frame_checker_top.sv
// Self-checking bench for gas_sensor_frame_checker_top: sends received bytes and read
// events, predicts each reading, and compares every accepted result with the oldest one.
// Depends on gsfc_pkg, gsfc_in_if, gsfc_out_if and the RTL of the block.
`timescale 1ns / 1ps

module tb_gas_sensor_frame_checker_top;

  localparam int CLK_HALF      = 6;
  localparam int IDLE_LIMIT    = 2000;
  localparam int DRAIN_CYCLES  = 20;
  localparam int RANDOM_ITEMS  = 1600;
  localparam int MAX_REPORTS   = 10;

  typedef logic [gsfc_pkg::FRAME_LEN-1:0][7:0] frame_t;

  typedef struct {
    logic [15:0]       ppm;
    gsfc_pkg::status_t status;
  } reading_t;

  logic clk = 1'b0;
  logic rst;

  gsfc_in_if  cmd_if ();
  gsfc_out_if rsp_if ();

  gas_sensor_frame_checker_top u_top (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_if.sink),
    .rsp (rsp_if.source)
  );

  // Shadow copy of the block's frame state
  frame_t      shadow_frame = '0;
  int          shadow_idx   = 0;
  logic        shadow_full  = 1'b0;
  logic [15:0] shadow_ppm   = '0;

  reading_t pending_readings[$];

  int  errors      = 0;
  int  mismatches  = 0;
  int  items_sent  = 0;
  int  idle_cycles = 0;
  bit  cmd_eager   = 1'b0;
  bit  rsp_eager   = 1'b0;
  int  rsp_hold    = 0;

  // Clock
  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // Track one accepted transaction and queue the reading it produces
  task automatic apply_cmd(input logic op, input logic [7:0] b);
    reading_t   r;
    logic [7:0] acc;
    logic [7:0] neg;
    int         k;
    if (op == gsfc_pkg::OP_BYTE) begin
      shadow_frame[shadow_idx] = b;
      if (shadow_idx == gsfc_pkg::FRAME_LEN - 1) begin
        shadow_idx  = 0;
        shadow_full = 1'b1;
      end else begin
        shadow_idx++;
      end
    end else begin
      acc = 8'h00;
      for (k = gsfc_pkg::SUM_FIRST; k <= gsfc_pkg::SUM_LAST; k++) begin
        acc = acc + shadow_frame[k];
      end
      neg = 8'h00 - acc;
      if (!shadow_full) begin
        shadow_ppm = '0;
        r.status   = gsfc_pkg::STATUS_NOT_READY;
      end else if (neg == shadow_frame[gsfc_pkg::CSUM_IDX]) begin
        shadow_ppm = {shadow_frame[gsfc_pkg::PPM_HI_IDX], shadow_frame[gsfc_pkg::PPM_LO_IDX]};
        r.status   = gsfc_pkg::STATUS_GOOD;
      end else begin
        r.status   = gsfc_pkg::STATUS_BAD_SUM;
      end
      r.ppm = shadow_ppm;
      pending_readings.push_back(r);
      shadow_frame = '0;
      shadow_full  = 1'b0;
      shadow_idx   = 0;
    end
  endtask

  // Offer one transaction after a random gap, hold it until accepted
  task automatic send_cmd(input logic op, input logic [7:0] b);
    int gap;
    gap = cmd_eager ? 0 : $urandom_range(0, 8);
    repeat (gap) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_if.valid   <= 1'b1;
    cmd_if.opcode  <= op;
    cmd_if.rx_byte <= b;
    do @(posedge clk); while (!cmd_if.ready);
    apply_cmd(op, b);
    items_sent++;
  endtask

  task automatic send_bytes(input frame_t f, input int count);
    int k;
    for (k = 0; k < count; k++) send_cmd(gsfc_pkg::OP_BYTE, f[k]);
  endtask

  // Build a frame with random content and a matching (or broken) checksum
  function automatic frame_t make_frame(input bit corrupt);
    frame_t     f;
    logic [7:0] acc;
    int         k;
    for (k = 0; k < gsfc_pkg::FRAME_LEN; k++) f[k] = 8'($urandom);
    case ($urandom_range(0, 5))
      0: begin
        f[gsfc_pkg::PPM_HI_IDX] = 8'h00;
        f[gsfc_pkg::PPM_LO_IDX] = 8'h00;
      end
      1: begin
        f[gsfc_pkg::PPM_HI_IDX] = 8'hFF;
        f[gsfc_pkg::PPM_LO_IDX] = 8'hFF;
      end
      default: ;
    endcase
    acc = 8'h00;
    for (k = gsfc_pkg::SUM_FIRST; k <= gsfc_pkg::SUM_LAST; k++) acc = acc + f[k];
    f[gsfc_pkg::CSUM_IDX] = 8'h00 - acc;
    if (corrupt) f[gsfc_pkg::CSUM_IDX] = f[gsfc_pkg::CSUM_IDX] ^ 8'($urandom_range(1, 255));
    return f;
  endfunction

  // Drop the offer and hold the sender until every queued reading has come back
  task automatic wait_drained();
    cmd_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_readings.size() != 0) @(posedge clk);
  endtask

  // Read with nothing received since reset
  task automatic test_not_ready_read();
    send_cmd(gsfc_pkg::OP_READ, 8'h00);
  endtask

  // Full frame at the ppm ceiling, then one more byte overwrites byte 0 only
  task automatic test_unchecked_byte0_overwrite();
    frame_t f;
    f                       = '0;
    f[gsfc_pkg::PPM_HI_IDX] = 8'hFF;
    f[gsfc_pkg::PPM_LO_IDX] = 8'hFF;
    f[gsfc_pkg::CSUM_IDX]   = 8'h02;
    send_bytes(f, gsfc_pkg::FRAME_LEN);
    send_cmd(gsfc_pkg::OP_BYTE, 8'hFF);
    send_cmd(gsfc_pkg::OP_READ, 8'h00);
  endtask

  // Wrong checksum keeps the held value
  task automatic test_checksum_mismatch();
    frame_t f;
    f                     = '0;
    f[gsfc_pkg::CSUM_IDX] = 8'hFF;
    send_bytes(f, gsfc_pkg::FRAME_LEN);
    send_cmd(gsfc_pkg::OP_READ, 8'hFF);
  endtask

  // A few bytes only, so the read reports not ready and zero
  task automatic test_partial_frame();
    send_cmd(gsfc_pkg::OP_BYTE, 8'hA5);
    send_cmd(gsfc_pkg::OP_BYTE, 8'h5A);
    send_cmd(gsfc_pkg::OP_READ, 8'h00);
  endtask

  // Receiver holds off while reads keep coming back to back
  task automatic test_result_backpressure();
    int n;
    cmd_eager = 1'b1;
    rsp_hold  = 200;
    for (n = 0; n < 4; n++) begin
      send_bytes(make_frame(n == 2), gsfc_pkg::FRAME_LEN);
      send_cmd(gsfc_pkg::OP_READ, 8'($urandom));
    end
    send_cmd(gsfc_pkg::OP_READ, 8'($urandom));
    send_cmd(gsfc_pkg::OP_READ, 8'($urandom));
    cmd_eager = 1'b0;
  endtask

  // Sender pauses until the block has returned every reading
  task automatic test_drain_pause();
    send_bytes(make_frame(1'b0), gsfc_pkg::FRAME_LEN);
    send_cmd(gsfc_pkg::OP_READ, 8'h00);
    wait_drained();
    send_bytes(make_frame(1'b1), gsfc_pkg::FRAME_LEN);
    send_cmd(gsfc_pkg::OP_READ, 8'h00);
    wait_drained();
  endtask

  // Mostly well-formed frames with random content, some broken ones and noise
  task automatic test_random_traffic();
    int     stop_at;
    int     sel;
    int     n;
    int     k;
    frame_t f;
    stop_at = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 9) == 0) cmd_eager = !cmd_eager;
      sel = $urandom_range(0, 99);
      if (sel < 60) begin
        send_bytes(make_frame(1'b0), gsfc_pkg::FRAME_LEN);
      end else if (sel < 75) begin
        send_bytes(make_frame(1'b1), gsfc_pkg::FRAME_LEN);
      end else if (sel < 85) begin
        f = make_frame(1'($urandom_range(0, 1)));
        send_bytes(f, gsfc_pkg::FRAME_LEN);
        n = $urandom_range(1, 4);
        for (k = 0; k < n; k++) send_cmd(gsfc_pkg::OP_BYTE, 8'($urandom));
      end else if (sel < 95) begin
        n = $urandom_range(0, gsfc_pkg::FRAME_LEN - 1);
        for (k = 0; k < n; k++) send_cmd(gsfc_pkg::OP_BYTE, 8'($urandom));
      end else begin
        n = $urandom_range(0, 20);
        for (k = 0; k < n; k++) send_cmd(gsfc_pkg::OP_BYTE, 8'($urandom));
      end
      send_cmd(gsfc_pkg::OP_READ, 8'($urandom));
    end
    cmd_eager = 1'b0;
  endtask

  // Stimulus and end of run
  initial begin
    rst            <= 1'b1;
    cmd_if.valid   <= 1'b0;
    cmd_if.opcode  <= gsfc_pkg::OP_BYTE;
    cmd_if.rx_byte <= 8'h00;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_not_ready_read();
    test_unchecked_byte0_overwrite();
    test_checksum_mismatch();
    test_partial_frame();
    test_result_backpressure();
    test_drain_pause();
    test_random_traffic();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Result side: random stalls, optional long hold-off, check each transaction
  initial begin
    int       stall;
    reading_t exp_r;
    rsp_if.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if ($urandom_range(0, 15) == 0) rsp_eager = !rsp_eager;
      stall    = (rsp_eager ? 0 : $urandom_range(0, 8)) + rsp_hold;
      rsp_hold = 0;
      if (stall > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (!rsp_if.valid);
      if (pending_readings.size() == 0) begin
        errors++;
        $display("unexpected reading: gas_ppm=%h read_status=%0d",
                 rsp_if.gas_ppm, rsp_if.read_status);
      end else begin
        exp_r = pending_readings.pop_front();
        if (rsp_if.gas_ppm !== exp_r.ppm || rsp_if.read_status !== exp_r.status) begin
          errors++;
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("reading mismatch: gas_ppm exp %h got %h, read_status exp %0d got %0d",
                     exp_r.ppm, rsp_if.gas_ppm, exp_r.status, rsp_if.read_status);
        end
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  always @(posedge clk) begin
    if (rst || (cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
